// ===== sv/aes_pkg.sv =====
// aes_pkg: shared types, constants and functions for the aes-128 round pipeline
// holds the s-box table, gf doubling, round and key-step functions
// no dependencies
package aes_pkg;

  typedef logic [127:0] block_t;
  typedef logic [7:0]   byte_t;
  typedef logic [3:0]   round_t;

  localparam int unsigned NumRounds = 10;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  // register indexes on the config port
  localparam logic RegKeyHigh = 1'b0;
  localparam logic RegKeyLow  = 1'b1;

  // byte n of a block, byte 0 in the top bits
  function automatic byte_t get_byte(block_t b, int unsigned n);
    get_byte = b[127 - 8*n -: 8];
  endfunction

  // multiply by x modulo the aes polynomial
  function automatic byte_t gf_double(byte_t b);
    gf_double = {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
  endfunction

  // round constant for round r (1..10)
  function automatic byte_t rcon(round_t r);
    case (r)
      4'd1:    rcon = 8'h01;
      4'd2:    rcon = 8'h02;
      4'd3:    rcon = 8'h04;
      4'd4:    rcon = 8'h08;
      4'd5:    rcon = 8'h10;
      4'd6:    rcon = 8'h20;
      4'd7:    rcon = 8'h40;
      4'd8:    rcon = 8'h80;
      4'd9:    rcon = 8'h1b;
      4'd10:   rcon = 8'h36;
      default: rcon = 8'h00;
    endcase
  endfunction

  // next round key from the current one
  function automatic block_t key_step(block_t rk, byte_t rc);
    byte_t  t [4];
    block_t o;
    for (int r = 0; r < 4; r++) t[r] = SBOX[get_byte(rk, 12 + ((r + 1) % 4))];
    t[0] = t[0] ^ rc;
    for (int r = 0; r < 4; r++) o[127 - 8*r -: 8] = get_byte(rk, r) ^ t[r];
    for (int c = 1; c < 4; c++)
      for (int r = 0; r < 4; r++)
        o[127 - 8*(4*c + r) -: 8] = get_byte(rk, 4*c + r) ^ o[127 - 8*(4*(c-1) + r) -: 8];
    key_step = o;
  endfunction

  // subbytes, shiftrows and optional mixcolumns
  function automatic block_t round_fn(block_t s, logic mix);
    block_t t;
    block_t o;
    byte_t  a0, a1, a2, a3, b0, b1, b2, b3;
    for (int c = 0; c < 4; c++)
      for (int r = 0; r < 4; r++)
        t[127 - 8*(4*c + r) -: 8] = SBOX[get_byte(s, 4*((c + r) % 4) + r)];
    o = t;
    for (int c = 0; c < 4; c++) begin
      a0 = get_byte(t, 4*c);     a1 = get_byte(t, 4*c + 1);
      a2 = get_byte(t, 4*c + 2); a3 = get_byte(t, 4*c + 3);
      b0 = gf_double(a0); b1 = gf_double(a1);
      b2 = gf_double(a2); b3 = gf_double(a3);
      if (mix) begin
        o[127 - 8*(4*c)     -: 8] = b0 ^ a1 ^ b1 ^ a2 ^ a3;
        o[127 - 8*(4*c + 1) -: 8] = a0 ^ b1 ^ a2 ^ b2 ^ a3;
        o[127 - 8*(4*c + 2) -: 8] = a0 ^ a1 ^ b2 ^ a3 ^ b3;
        o[127 - 8*(4*c + 3) -: 8] = a0 ^ b0 ^ a1 ^ a2 ^ b3;
      end
    end
    round_fn = o;
  endfunction

endpackage

// ===== sv/aes128_block_encrypt.sv =====
// aes128_block_encrypt: aes-128 encryption as a chain of ten round cells
// depends on aes_pkg and aes_round_cell
//
//  channel  signals                          direction
//  input    start, busy, plain_high/low      in, word taken when start && !busy
//  output   done, cipher_high/low            out, word valid for one cycle
//  config   psel penable pwrite paddr pwdata in, key_high at 0, key_low at 8
//
// one word accepted every cycle; busy is always low
// each word passes one input register with initial addroundkey, then ten round cells
// reset clears the valid chain and both key registers
// the receiver cannot stall, so no backpressure exists in the chain
module aes128_block_encrypt (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [63:0] plain_high,
  input  logic [63:0] plain_low,
  output logic        done,
  output logic [63:0] cipher_high,
  output logic [63:0] cipher_low,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);

  localparam int unsigned N = aes_pkg::NumRounds;

  logic [63:0]     key_high;
  logic [63:0]     key_low;
  logic            v     [N+1];
  aes_pkg::block_t st    [N+1];
  aes_pkg::block_t rk    [N+1];
  logic            wr_en;

  assign busy   = 1'b0;
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && (paddr[2:0] == 3'd0);

  // key registers
  always_ff @(posedge clk) begin
    if (rst) begin
      key_high <= '0;
      key_low  <= '0;
    end else if (wr_en) begin
      if (paddr[3] == aes_pkg::RegKeyHigh) key_high <= pwdata;
      else                                 key_low  <= pwdata;
    end
  end

  assign prdata = (paddr[3] == aes_pkg::RegKeyHigh) ? key_high : key_low;

  // input stage with initial addroundkey
  always_ff @(posedge clk) begin
    if (rst) v[0] <= 1'b0;
    else     v[0] <= start;
  end

  always_ff @(posedge clk) begin
    st[0] <= {plain_high, plain_low} ^ {key_high, key_low};
    rk[0] <= {key_high, key_low};
  end

  // chain of round cells
  for (genvar i = 0; i < N; i++) begin : g_round
    aes_round_cell #(.ROUND(4'(i + 1))) u_cell (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (v[i]),
      .in_state  (st[i]),
      .in_key    (rk[i]),
      .out_valid (v[i+1]),
      .out_state (st[i+1]),
      .out_key   (rk[i+1])
    );
  end

  assign done        = v[N];
  assign cipher_high = st[N][127:64];
  assign cipher_low  = st[N][63:0];

  // done follows start by the pipeline depth
  a_latency: assert property (@(posedge clk) disable iff (rst)
    v[0] |-> ##10 done) else $error("result missing");
  a_first: assert property (@(posedge clk) disable iff (rst)
    v[0] |=> v[1]) else $error("valid lost in first cell");
  a_idle: assert property (@(posedge clk) disable iff (rst)
    !v[0] |-> ##10 !done) else $error("spurious result");

endmodule

// ===== sv/aes_round_cell.sv =====
// aes_round_cell: one pipeline cell, one aes round plus its key expansion step
// depends on aes_pkg
module aes_round_cell #(
  parameter logic [3:0] ROUND = 4'd1
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  input  aes_pkg::block_t in_state,
  input  aes_pkg::block_t in_key,
  output logic            out_valid,
  output aes_pkg::block_t out_state,
  output aes_pkg::block_t out_key
);

  aes_pkg::block_t key_next;

  // expand this round's key and fold it into the state
  assign key_next = aes_pkg::key_step(in_key, aes_pkg::rcon(ROUND));

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    out_state <= aes_pkg::round_fn(in_state, ROUND != 4'(aes_pkg::NumRounds)) ^ key_next;
    out_key   <= key_next;
  end

endmodule
